// ===== hw/rtl/tpdq_pkg.sv =====
package tpdq_pkg;

  localparam int MAX_NODES = 1024;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int COUNT_W   = $clog2(MAX_NODES + 1);
  localparam int WEIGHT_W  = 31;
  localparam int DIST_W    = 41;
  localparam int CFG_W     = 11;
  localparam int STEP_W    = 4;

  localparam logic [CFG_W-1:0] NODE_COUNT_RESET = CFG_W'(2);

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic                func;
    logic [9:0]          node_a;
    logic [9:0]          node_b;
    logic [WEIGHT_W-1:0] edge_weight_in;
  } tpdq_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              bad_node;
  } tpdq_out_t;

  typedef struct packed {
    logic [NODE_W-1:0]   parent;
    logic [WEIGHT_W-1:0] weight;
  } tpdq_tree_t;

  typedef struct packed {
    logic              mark;
    logic [DIST_W-1:0] offset;
  } tpdq_anc_t;

  // Microprogram addresses.
  localparam logic [STEP_W-1:0] S_CLR  = 4'd0;
  localparam logic [STEP_W-1:0] S_IDLE = 4'd1;
  localparam logic [STEP_W-1:0] S_P1A  = 4'd2;
  localparam logic [STEP_W-1:0] S_P1B  = 4'd3;
  localparam logic [STEP_W-1:0] S_P1C  = 4'd4;
  localparam logic [STEP_W-1:0] S_P2I  = 4'd5;
  localparam logic [STEP_W-1:0] S_P2A  = 4'd6;
  localparam logic [STEP_W-1:0] S_P2B  = 4'd7;
  localparam logic [STEP_W-1:0] S_P2C  = 4'd8;
  localparam logic [STEP_W-1:0] S_P2D  = 4'd9;
  localparam logic [STEP_W-1:0] S_MISS = 4'd10;
  localparam logic [STEP_W-1:0] S_HIT  = 4'd11;
  localparam logic [STEP_W-1:0] S_CLRI = 4'd12;
  localparam logic [STEP_W-1:0] S_CLRA = 4'd13;
  localparam logic [STEP_W-1:0] S_CLRB = 4'd14;
  localparam logic [STEP_W-1:0] S_EMIT = 4'd15;

  typedef enum logic [2:0] {
    BR_NEXT, BR_GOTO, BR_IF, BR_HOLD, BR_DISPATCH
  } tpdq_br_t;

  typedef enum logic [2:0] {
    C_NONE, C_CUR_ZERO, C_CUR_NOT_LAST, C_NOT_MARKED, C_MARKED,
    C_STEPS_MORE, C_COUNT_ONE, C_OUT_FREE
  } tpdq_cond_t;

  typedef enum logic [2:0] {
    CUR_HOLD, CUR_INC, CUR_IN, CUR_SRC, CUR_DST, CUR_PARENT
  } tpdq_cur_op_t;

  typedef enum logic [1:0] {
    D_HOLD, D_ZERO, D_ADD_W, D_ADD_ANC
  } tpdq_d_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD, CNT_ZERO, CNT_INC, CNT_DEC
  } tpdq_cnt_op_t;

  typedef enum logic [1:0] {
    ST_HOLD, ST_ZERO, ST_INC
  } tpdq_st_op_t;

  typedef enum logic [1:0] {
    BAD_HOLD, BAD_IN, BAD_SET, BAD_CLR
  } tpdq_bad_op_t;

  typedef enum logic [1:0] {
    ANC_RD_NONE, ANC_RD_CUR, ANC_RD_PARENT
  } tpdq_anc_rd_t;

  typedef struct packed {
    tpdq_br_t          br;
    tpdq_cond_t        cond;
    logic [STEP_W-1:0] target;
    tpdq_cur_op_t      cur_op;
    tpdq_d_op_t        d_op;
    tpdq_cnt_op_t      cnt_op;
    tpdq_st_op_t       st_op;
    tpdq_bad_op_t      bad_op;
    tpdq_anc_rd_t      anc_rd;
    logic              anc_we;
    logic              anc_mark;
    logic              tree_re;
    logic              in_rdy;
    logic              out_load;
  } tpdq_uword_t;

  localparam tpdq_uword_t UW_NOP = '{
    br: BR_NEXT, cond: C_NONE, target: S_IDLE, cur_op: CUR_HOLD, d_op: D_HOLD,
    cnt_op: CNT_HOLD, st_op: ST_HOLD, bad_op: BAD_HOLD, anc_rd: ANC_RD_NONE,
    anc_we: 1'b0, anc_mark: 1'b0, tree_re: 1'b0, in_rdy: 1'b0, out_load: 1'b0
  };

  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] x,
                                                input logic [DIST_W-1:0] y);
    logic [DIST_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
  endfunction

  function automatic tpdq_uword_t ucode_rom(input logic [STEP_W-1:0] step);
    tpdq_uword_t w;
    w = UW_NOP;
    unique case (step)
      S_CLR: begin
        w.anc_we = 1'b1; w.cur_op = CUR_INC; w.cnt_op = CNT_ZERO;
        w.br = BR_IF; w.cond = C_CUR_NOT_LAST; w.target = S_CLR;
      end
      S_IDLE: begin
        w.in_rdy = 1'b1; w.cur_op = CUR_IN; w.d_op = D_ZERO;
        w.cnt_op = CNT_ZERO; w.bad_op = BAD_IN; w.br = BR_DISPATCH;
      end
      S_P1A: begin
        w.anc_we = 1'b1; w.anc_mark = 1'b1; w.tree_re = 1'b1; w.cnt_op = CNT_INC;
        w.br = BR_IF; w.cond = C_CUR_ZERO; w.target = S_P2I;
      end
      S_P1B: begin
        w.d_op = D_ADD_W; w.cur_op = CUR_PARENT; w.anc_rd = ANC_RD_PARENT;
      end
      S_P1C: begin
        w.br = BR_IF; w.cond = C_NOT_MARKED; w.target = S_P1A;
      end
      S_P2I: begin
        w.cur_op = CUR_DST; w.d_op = D_ZERO; w.st_op = ST_ZERO;
      end
      S_P2A: begin
        w.anc_rd = ANC_RD_CUR; w.tree_re = 1'b1;
      end
      S_P2B: begin
        w.br = BR_IF; w.cond = C_MARKED; w.target = S_HIT;
      end
      S_P2C: begin
        w.br = BR_IF; w.cond = C_CUR_ZERO; w.target = S_MISS;
      end
      S_P2D: begin
        w.d_op = D_ADD_W; w.cur_op = CUR_PARENT; w.st_op = ST_INC;
        w.br = BR_IF; w.cond = C_STEPS_MORE; w.target = S_P2A;
      end
      S_MISS: begin
        w.d_op = D_ZERO; w.bad_op = BAD_SET; w.br = BR_GOTO; w.target = S_CLRI;
      end
      S_HIT: begin
        w.d_op = D_ADD_ANC; w.bad_op = BAD_CLR;
      end
      S_CLRI: begin
        w.cur_op = CUR_SRC;
      end
      S_CLRA: begin
        w.anc_we = 1'b1; w.tree_re = 1'b1; w.cnt_op = CNT_DEC;
        w.br = BR_IF; w.cond = C_COUNT_ONE; w.target = S_EMIT;
      end
      S_CLRB: begin
        w.cur_op = CUR_PARENT; w.br = BR_GOTO; w.target = S_CLRA;
      end
      S_EMIT: begin
        w.out_load = 1'b1; w.br = BR_HOLD; w.cond = C_OUT_FREE; w.target = S_IDLE;
      end
      default: w = UW_NOP;
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/tree_path_distance_query.sv =====
// Weighted tree path distance engine.
// Input channel in_valid/in_ready/in_data carries load and query items; a
// transfer happens when valid and ready are both high. A load writes the
// parent and edge weight of one child node and produces no result; loads are
// taken one per cycle while no query is in progress. A query produces one
// transfer on out_valid/out_ready/out_data with the path distance, or
// bad_node set when a node is out of range or no path exists.
// A query marks the source's ancestors, walks up from the destination, then
// walks the source chain again to clear the marks. A walk caught in a
// reloaded cycle is bounded; a node-range error goes straight to the result
// step.
// After reset the block sweeps the 1024-entry mark memory, one entry per
// cycle, and accepts no item until the sweep is done. node_count is written
// through cfg_we/cfg_wdata and resets to 2.
// The result sits in an output register; if the receiver stalls, loads are
// still accepted, but the next query holds in its final step until the
// register is taken and accepts no item meanwhile.
module tree_path_distance_query (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tpdq_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tpdq_pkg::tpdq_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tpdq_pkg::tpdq_out_t           out_data
);
  import tpdq_pkg::*;

  tpdq_tree_t tree_mem [MAX_NODES];
  tpdq_anc_t  anc_mem  [MAX_NODES];

  logic [CFG_W-1:0]   node_count;
  logic [STEP_W-1:0]  upc, upc_next;
  logic [NODE_W-1:0]  cur, src, dst;
  logic [DIST_W-1:0]  d;
  logic [COUNT_W-1:0] cnt, steps;
  logic               bad;
  tpdq_tree_t         tree_rdata;
  tpdq_anc_t          anc_rdata;

  tpdq_uword_t        cw;
  logic [CFG_W-1:0]   eff_n;
  logic               accept, load_ok, query_bad, cond_true, out_free;
  logic               anc_re;
  logic [NODE_W-1:0]  anc_raddr;

  assign cw        = ucode_rom(upc);
  assign in_ready  = cw.in_rdy;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign eff_n     = (node_count > CFG_W'(MAX_NODES)) ? CFG_W'(MAX_NODES) : node_count;
  assign query_bad = (CFG_W'(in_data.node_a) >= eff_n) || (CFG_W'(in_data.node_b) >= eff_n);
  assign load_ok   = (in_data.node_a != '0) && (CFG_W'(in_data.node_a) < eff_n) &&
                     (CFG_W'(in_data.node_b) < eff_n);
  assign anc_re    = (cw.anc_rd != ANC_RD_NONE);
  assign anc_raddr = (cw.anc_rd == ANC_RD_PARENT) ? tree_rdata.parent : cur;

  always_comb begin
    unique case (cw.cond)
      C_NONE:         cond_true = 1'b0;
      C_CUR_ZERO:     cond_true = (cur == '0);
      C_CUR_NOT_LAST: cond_true = (cur != NODE_W'(MAX_NODES - 1));
      C_NOT_MARKED:   cond_true = !anc_rdata.mark;
      C_MARKED:       cond_true = anc_rdata.mark;
      C_STEPS_MORE:   cond_true = (steps != COUNT_W'(MAX_NODES));
      C_COUNT_ONE:    cond_true = (cnt == COUNT_W'(1));
      C_OUT_FREE:     cond_true = out_free;
      default:        cond_true = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cw.br)
      BR_NEXT:     upc_next = upc + STEP_W'(1);
      BR_GOTO:     upc_next = cw.target;
      BR_IF:       upc_next = cond_true ? cw.target : upc + STEP_W'(1);
      BR_HOLD:     upc_next = cond_true ? cw.target : upc;
      BR_DISPATCH: begin
        if (accept && in_data.func == FUNC_QUERY) begin
          upc_next = query_bad ? S_EMIT : S_P1A;
        end else begin
          upc_next = upc;
        end
      end
      default:     upc_next = upc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc        <= S_CLR;
      cur        <= '0;
      node_count <= NODE_COUNT_RESET;
      out_valid  <= 1'b0;
    end else begin
      upc <= upc_next;
      if (cfg_we) begin
        node_count <= cfg_wdata;
      end
      unique case (cw.cur_op)
        CUR_HOLD:   cur <= cur;
        CUR_INC:    cur <= cur + NODE_W'(1);
        CUR_IN:     cur <= in_data.node_a;
        CUR_SRC:    cur <= src;
        CUR_DST:    cur <= dst;
        CUR_PARENT: cur <= tree_rdata.parent;
        default:    cur <= cur;
      endcase
      if (cw.out_load && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cw.cur_op == CUR_IN) begin
      src <= in_data.node_a;
      dst <= in_data.node_b;
    end
    unique case (cw.d_op)
      D_HOLD:    d <= d;
      D_ZERO:    d <= '0;
      D_ADD_W:   d <= sat_add(d, DIST_W'(tree_rdata.weight));
      D_ADD_ANC: d <= sat_add(d, anc_rdata.offset);
      default:   d <= d;
    endcase
    unique case (cw.cnt_op)
      CNT_HOLD: cnt <= cnt;
      CNT_ZERO: cnt <= '0;
      CNT_INC:  cnt <= cnt + COUNT_W'(1);
      CNT_DEC:  cnt <= cnt - COUNT_W'(1);
      default:  cnt <= cnt;
    endcase
    unique case (cw.st_op)
      ST_HOLD: steps <= steps;
      ST_ZERO: steps <= '0;
      ST_INC:  steps <= steps + COUNT_W'(1);
      default: steps <= steps;
    endcase
    unique case (cw.bad_op)
      BAD_HOLD: bad <= bad;
      BAD_IN:   bad <= query_bad;
      BAD_SET:  bad <= 1'b1;
      BAD_CLR:  bad <= 1'b0;
      default:  bad <= bad;
    endcase
    if (cw.out_load && out_free) begin
      out_data.distance <= d;
      out_data.bad_node <= bad;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.func == FUNC_LOAD && load_ok) begin
      tree_mem[in_data.node_a] <= '{parent: in_data.node_b, weight: in_data.edge_weight_in};
    end
    if (cw.tree_re) begin
      tree_rdata <= tree_mem[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (cw.anc_we) begin
      anc_mem[cur] <= '{mark: cw.anc_mark, offset: d};
    end
    if (anc_re) begin
      anc_rdata <= anc_mem[anc_raddr];
    end
  end

  a_clear_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (upc == S_CLRA) |-> (cnt != '0))
    else $error("Mark clearing walk started with no marks recorded.");

  a_marks_bounded: assert property (@(posedge clk) disable iff (rst)
    (cnt <= COUNT_W'(MAX_NODES)))
    else $error("Mark count exceeds the number of nodes.");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(upc) == S_EMIT))
    else $error("Result register loaded outside the emit step.");

endmodule

// ===== bench/tree_path_distance_query_tb.sv =====
module tree_path_distance_query_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpdq_pkg::*;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [CFG_W-1:0]    cfg_value;
    logic                func;
    logic [9:0]          node_a;
    logic [9:0]          node_b;
    logic [WEIGHT_W-1:0] weight;
    logic                known;
    logic [DIST_W-1:0]   distance;
    logic                bad_node;
  } stim_row_t;

  localparam longint unsigned DIST_LIMIT = (64'd1 << DIST_W) - 64'd1;

  localparam stim_row_t DIRECTED_ROWS [26] = '{
    '{ROW_CFG,  11'd2,    FUNC_LOAD,  10'd0,    10'd0,    31'd0,          1'b0, 41'd0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_QUERY, 10'd0,    10'd0,    31'd0,          1'b1, 41'd0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_LOAD,  10'd1,    10'd0,    31'h7fffffff,   1'b0, 41'd0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_QUERY, 10'd1,    10'd0,    31'd0,
      1'b1, 41'd2147483647, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_QUERY, 10'd0,    10'd1,    31'd12345,
      1'b1, 41'd2147483647, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_QUERY, 10'd1,    10'd1,    31'd0,          1'b1, 41'd0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_QUERY, 10'd2,    10'd0,    31'd0,          1'b1, 41'd0, 1'b1},
    '{ROW_ITEM, 11'd0,    FUNC_QUERY, 10'd1023, 10'd1023, 31'h7fffffff,   1'b1, 41'd0, 1'b1},
    '{ROW_ITEM, 11'd0,    FUNC_LOAD,  10'd0,    10'd1,    31'd5,          1'b0, 41'd0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_LOAD,  10'd1023, 10'd0,    31'd9,          1'b0, 41'd0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_LOAD,  10'd1,    10'd1023, 31'd3,          1'b0, 41'd0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_QUERY, 10'd1,    10'd0,    31'd0,
      1'b1, 41'd2147483647, 1'b0},
    '{ROW_CFG,  11'd1024, FUNC_LOAD,  10'd0,    10'd0,    31'd0,          1'b0, 41'd0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_LOAD,  10'd2,    10'd1,    31'd0,          1'b0, 41'd0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_LOAD,  10'd3,    10'd1,    31'd7,          1'b0, 41'd0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_LOAD,  10'd1023, 10'd3,    31'd100,        1'b0, 41'd0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_LOAD,  10'd4,    10'd2,    31'd5,          1'b0, 41'd0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_QUERY, 10'd1023, 10'd4,    31'd0,          1'b0, 41'd0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_QUERY, 10'd4,    10'd1023, 31'd77,         1'b0, 41'd0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_QUERY, 10'd1023, 10'd1023, 31'd0,          1'b1, 41'd0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_LOAD,  10'd1,    10'd3,    31'd1,          1'b0, 41'd0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_QUERY, 10'd4,    10'd0,    31'd0,          1'b1, 41'd0, 1'b1},
    '{ROW_ITEM, 11'd0,    FUNC_QUERY, 10'd1023, 10'd2,    31'd0,          1'b0, 41'd0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_QUERY, 10'd0,    10'd4,    31'd0,          1'b1, 41'd0, 1'b1},
    '{ROW_ITEM, 11'd0,    FUNC_LOAD,  10'd1,    10'd0,    31'd11,         1'b0, 41'd0, 1'b0},
    '{ROW_ITEM, 11'd0,    FUNC_QUERY, 10'd4,    10'd1023, 31'd0,          1'b0, 41'd0, 1'b0}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  tpdq_in_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  tpdq_out_t        out_data;

  logic [CFG_W-1:0]    node_count_cfg = NODE_COUNT_RESET;
  logic [9:0]          tree_parent [MAX_NODES] = '{default: '0};
  logic [WEIGHT_W-1:0] tree_weight [MAX_NODES] = '{default: '0};
  bit                  node_loaded [MAX_NODES] = '{default: 1'b0};
  logic [9:0]          loaded_nodes [$];
  tpdq_out_t           expected_results [$];
  tpdq_out_t           oldest_expected;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int ready_hold_cycles = 0;
  int mismatch_count = 0;
  int results_seen = 0;
  int flagged_results = 0;
  int loads_sent = 0;
  int queries_sent = 0;
  int cfg_writes = 0;

  tree_path_distance_query dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic int active_nodes();
    return (node_count_cfg < MAX_NODES) ? int'(node_count_cfg) : MAX_NODES;
  endfunction

  function automatic logic [DIST_W-1:0] capped_sum(input logic [DIST_W-1:0] x,
                                                   input logic [DIST_W-1:0] y);
    longint unsigned total;
    total = longint'(x) + longint'(y);
    if (total > DIST_LIMIT) total = DIST_LIMIT;
    return total[DIST_W-1:0];
  endfunction

  // The source's ancestors are tagged with their distance from the source, then
  // the destination climbs until it reaches a tagged node.
  function automatic bit trace_path(input logic [9:0] src, input logic [9:0] dst,
                                    output logic [DIST_W-1:0] path_len);
    bit                on_src_chain [MAX_NODES];
    logic [DIST_W-1:0] src_dist [MAX_NODES];
    logic [9:0]        cur;
    logic [DIST_W-1:0] acc;
    on_src_chain = '{default: 1'b0};
    path_len = '0;
    cur = src;
    acc = '0;
    for (int s = 0; s < MAX_NODES; s++) begin
      on_src_chain[cur] = 1'b1;
      src_dist[cur] = acc;
      if (cur == 0) break;
      acc = capped_sum(acc, DIST_W'(tree_weight[cur]));
      cur = tree_parent[cur];
      if (on_src_chain[cur]) break;
    end
    cur = dst;
    acc = '0;
    for (int s = 0; s <= MAX_NODES; s++) begin
      if (on_src_chain[cur]) begin
        path_len = capped_sum(acc, src_dist[cur]);
        return 1'b1;
      end
      if (cur == 0) break;
      acc = capped_sum(acc, DIST_W'(tree_weight[cur]));
      cur = tree_parent[cur];
    end
    return 1'b0;
  endfunction

  function automatic bit model_item(input tpdq_in_t item, output tpdq_out_t res);
    int                n;
    logic [DIST_W-1:0] path_len;
    n = active_nodes();
    res = '0;
    if (item.func == FUNC_LOAD) begin
      if (item.node_a != 0 && item.node_a < n && item.node_b < n) begin
        tree_parent[item.node_a] = item.node_b;
        tree_weight[item.node_a] = item.edge_weight_in;
        if (!node_loaded[item.node_a]) begin
          node_loaded[item.node_a] = 1'b1;
          loaded_nodes = {loaded_nodes, item.node_a};
        end
      end
      return 1'b0;
    end
    if (item.node_a >= n || item.node_b >= n) begin
      res.bad_node = 1'b1;
    end else if (trace_path(item.node_a, item.node_b, path_len)) begin
      res.distance = path_len;
    end else begin
      res.bad_node = 1'b1;
    end
    return 1'b1;
  endfunction

  // Every loaded node climbs through loaded nodes only, so any of them is a
  // safe query endpoint or parent.
  function automatic logic [9:0] pick_node(input int n);
    logic [9:0] cand;
    if (loaded_nodes.size() > 0 && $urandom_range(0, 7) != 0) begin
      repeat (4) begin
        cand = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
        if (cand < n) return cand;
      end
    end
    cand = 10'($urandom_range(0, n - 1));
    return (cand == 0 || node_loaded[cand]) ? cand : 10'd0;
  endfunction

  task automatic transfer_item(input tpdq_in_t item, input bit use_typed,
                               input tpdq_out_t typed);
    tpdq_out_t predicted;
    bit        gives_result;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    gives_result = model_item(item, predicted);
    if (item.func == FUNC_LOAD) loads_sent++;
    else queries_sent++;
    if (gives_result) expected_results = {expected_results, (use_typed ? typed : predicted)};
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_node_count(input logic [CFG_W-1:0] value);
    drain_results();
    repeat (16) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    node_count_cfg = value;
    cfg_writes++;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (ready_hold_cycles > 0) begin
        out_ready <= 1'b0;
        ready_hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (out_data.bad_node) flagged_results++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result: distance %0d bad_node %0b",
                   out_data.distance, out_data.bad_node);
      end else begin
        oldest_expected = expected_results.pop_front();
        if (out_data.distance !== oldest_expected.distance ||
            out_data.bad_node !== oldest_expected.bad_node) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Result %0d: expected %0d/%0b, got %0d/%0b (distance/bad_node)",
                     results_seen, oldest_expected.distance, oldest_expected.bad_node,
                     out_data.distance, out_data.bad_node);
        end
      end
    end
  end

  initial begin
    #200_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int        phase_nodes [5];
    int        phase_send_idle [5];
    int        phase_recv_stall [5];
    int        phase_items [5];
    int        n;
    int        done;
    int        roll;
    bit        counts;
    bit        paused;
    logic [9:0] swap_node;
    stim_row_t row;
    tpdq_in_t  item;
    tpdq_out_t typed;

    phase_nodes = '{16, 1024, 64, 0, 2};
    phase_send_idle = '{0, 50, 0, 23, 0};
    phase_recv_stall = '{0, 0, 50, 23, 0};
    phase_items = '{55, 60, 55, 60, 35};
    phase_nodes[3] = $urandom_range(3, 1023);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_CFG) begin
        write_node_count(row.cfg_value);
      end else begin
        item = '{func: row.func, node_a: row.node_a, node_b: row.node_b,
                 edge_weight_in: row.weight};
        typed = '{distance: row.distance, bad_node: row.bad_node};
        transfer_item(item, row.known, typed);
      end
    end

    for (int phase = 0; phase < 5; phase++) begin
      write_node_count(CFG_W'(phase_nodes[phase]));
      send_idle_pct = phase_send_idle[phase];
      recv_stall_pct = phase_recv_stall[phase];
      // A long receiver stall with a busy sender fills the output register
      // and backs the input up behind the next query.
      if (phase == 2) ready_hold_cycles = 2000;
      n = active_nodes();
      done = 0;
      paused = 1'b0;
      while (done < phase_items[phase]) begin
        if (phase == 1 && done == 30 && !paused) begin
          drain_results();
          paused = 1'b1;
        end
        roll = $urandom_range(0, 99);
        counts = 1'b1;
        item.edge_weight_in = WEIGHT_W'($urandom());
        case ($urandom_range(0, 7))
          0: item.edge_weight_in = '0;
          1: item.edge_weight_in = '1;
          default: ;
        endcase
        if (roll < 35) begin
          item.func = FUNC_LOAD;
          item.node_a = 10'($urandom_range(1, n - 1));
          item.node_b = pick_node(n);
          if (item.node_b >= item.node_a && $urandom_range(0, 9) != 0) item.node_b = '0;
        end else if (roll < 90) begin
          item.func = FUNC_QUERY;
          item.node_a = pick_node(n);
          item.node_b = pick_node(n);
        end else if (n < MAX_NODES && roll < 95) begin
          item.func = FUNC_QUERY;
          item.node_a = 10'($urandom_range(n, MAX_NODES - 1));
          item.node_b = 10'($urandom_range(0, MAX_NODES - 1));
          if ($urandom_range(0, 1) == 1) begin
            swap_node = item.node_a;
            item.node_a = item.node_b;
            item.node_b = swap_node;
          end
        end else begin
          counts = 1'b0;
          item.func = FUNC_LOAD;
          item.node_a = '0;
          item.node_b = 10'($urandom_range(0, MAX_NODES - 1));
          if (n < MAX_NODES && $urandom_range(0, 1) == 1) begin
            item.node_a = 10'($urandom_range(1, MAX_NODES - 1));
            item.node_b = 10'($urandom_range(n, MAX_NODES - 1));
            if ($urandom_range(0, 1) == 1) begin
              swap_node = item.node_a;
              item.node_a = item.node_b;
              item.node_b = swap_node;
            end
          end
        end
        transfer_item(item, 1'b0, '0);
        if (counts) done++;
      end
    end

    drain_results();
    repeat (40) @(posedge clk);

    $display("Covered %0d loads and %0d queries over %0d node-count settings;",
             loads_sent, queries_sent, cfg_writes);
    $display("%0d results checked, %0d of them flagged bad_node.",
             results_seen, flagged_results);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
